[rtl/hsl_hsv_to_rgb_top_defines.svh]
// Assertion macros shared by the color converter RTL.
`ifndef HSL_HSV_TO_RGB_TOP_DEFINES_SVH
`define HSL_HSV_TO_RGB_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define HSL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsl_hsv_to_rgb: same-cycle check failed");

// Check that cons holds after ante, delayed by the dly argument.
`define HSL_ASSERT_DLY(name, clk, rst_n, ante, dly, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("hsl_hsv_to_rgb: delayed check failed");

`endif

[rtl/hsl_pkg.sv]
// Shared types and constants for the HSL/HSV to RGB converter.
`timescale 1ns / 1ps

package hsl_pkg;

  localparam int HUE_W    = 9;
  localparam int CH_W     = 8;
  localparam int W_W      = 6;
  localparam int CN_W     = 16;
  localparam int XW_W     = 22;
  localparam int T_W      = 17;
  localparam int NUM_W    = 23;
  localparam int Q_W      = 9;

  localparam int HUE_FULL   = 360;
  localparam int SECTOR_DEG = 60;
  localparam int LW_SCALE   = 510;
  localparam int C_SCALE    = 120;
  localparam int M_SCALE    = 60;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  // floor(n / 30600) == (n * RECIP) >> RECIP_SHIFT for n < 2**NUM_W
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 38;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = 24'd8982939;

  localparam int LATENCY = 5;

  typedef enum logic {
    MODE_HSL = 1'b0,
    MODE_HSV = 1'b1
  } color_mode_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

[rtl/hsl_div.sv]
// Registered divide of a channel numerator by 30600 with saturation to 8 bits.
`timescale 1ns / 1ps

module hsl_div (
  input  logic                     clk,
  input  logic [hsl_pkg::NUM_W-1:0] num,
  output logic [hsl_pkg::CH_W-1:0]  quo
);
  import hsl_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q;
  logic [CH_W-1:0]   quo_nxt;
  logic [CH_W-1:0]   quo_r;

  always_comb begin
    prod    = PROD_W'(num) * PROD_W'(RECIP);
    q       = prod[RECIP_SHIFT +: Q_W];
    quo_nxt = (q > Q_W'(CH_MAX)) ? CH_MAX : q[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

[rtl/hsl_hsv_to_rgb_top.sv]
// Top level of the pipelined HSL/HSV to RGB pixel converter.
//
//   channel   signals                                    handshake
//   request   start, busy, in_hue/saturation/lightness   start && !busy
//   result    out_strobe, out_red/green/blue             out_strobe, one cycle
//   config    cfg_wr_en, cfg_wr_data                     cfg_wr_en
//
// One pixel per clock; busy is always low.
// The result is registered through the stages wrap/sector, chroma multiply,
// hue-weight multiply, offset/sector select and reciprocal divide, in that order.
// Synchronous active-low reset clears the stage valid bits and the mode.
// The receiver cannot stall, so no stage ever holds.
`timescale 1ns / 1ps
`include "hsl_hsv_to_rgb_top_defines.svh"

module hsl_hsv_to_rgb_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [hsl_pkg::HUE_W-1:0] in_hue,
  input  logic [hsl_pkg::CH_W-1:0]  in_saturation,
  input  logic [hsl_pkg::CH_W-1:0]  in_lightness,
  output logic                      out_strobe,
  output logic [hsl_pkg::CH_W-1:0]  out_red,
  output logic [hsl_pkg::CH_W-1:0]  out_green,
  output logic [hsl_pkg::CH_W-1:0]  out_blue,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data
);
  import hsl_pkg::*;

  color_mode_t color_mode_r;

  // stage 1 inputs
  logic              v1_nxt;
  logic [HUE_W-1:0]  hue_wrap;
  logic [HUE_W-1:0]  w_full;
  sector_t           sec1_nxt;
  logic [W_W-1:0]    w1_nxt;
  logic [HUE_W-1:0]  twol;
  logic [HUE_W-1:0]  l_fold;
  logic [CH_W-1:0]   a1_nxt;

  logic              v1_r, v2_r, v3_r, v4_r, v5_r;
  sector_t           sec1_r, sec2_r, sec3_r;
  logic [W_W-1:0]    w1_r, w2_r;
  logic [CH_W-1:0]   a1_r, s1_r, l1_r, l2_r;
  color_mode_t       mode1_r, mode2_r;

  logic [CN_W-1:0]   cn2_nxt, cn2_r, cn3_r;
  logic [XW_W-1:0]   xw3_nxt, xw3_r;
  logic [T_W:0]      lw3, kcn3, diff3;
  logic [T_W-1:0]    t3_nxt, t3_r;

  logic [NUM_W-1:0]  c4, x4, m4;
  logic [NUM_W-1:0]  pr4, pg4, pb4;
  logic [NUM_W-1:0]  numr_nxt, numg_nxt, numb_nxt;
  logic [NUM_W-1:0]  numr_r, numg_r, numb_r;

  logic              gray_req, black_req, rgb_equal, rgb_zero;

  assign busy   = 1'b0;
  assign v1_nxt = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= MODE_HSL;
    end else if (cfg_wr_en) begin
      color_mode_r <= color_mode_t'(cfg_wr_data);
    end
  end

  // wrap hue, find sector and hue weight, fold lightness for HSL chroma
  always_comb begin
    hue_wrap = (in_hue >= HUE_W'(HUE_FULL)) ? in_hue - HUE_W'(HUE_FULL) : in_hue;
    if (hue_wrap < HUE_W'(SECTOR_DEG)) begin
      sec1_nxt = SEC_RED_YEL;
      w_full   = hue_wrap;
    end else if (hue_wrap < HUE_W'(2 * SECTOR_DEG)) begin
      sec1_nxt = SEC_YEL_GRN;
      w_full   = HUE_W'(2 * SECTOR_DEG) - hue_wrap;
    end else if (hue_wrap < HUE_W'(3 * SECTOR_DEG)) begin
      sec1_nxt = SEC_GRN_CYN;
      w_full   = hue_wrap - HUE_W'(2 * SECTOR_DEG);
    end else if (hue_wrap < HUE_W'(4 * SECTOR_DEG)) begin
      sec1_nxt = SEC_CYN_BLU;
      w_full   = HUE_W'(4 * SECTOR_DEG) - hue_wrap;
    end else if (hue_wrap < HUE_W'(5 * SECTOR_DEG)) begin
      sec1_nxt = SEC_BLU_MAG;
      w_full   = hue_wrap - HUE_W'(4 * SECTOR_DEG);
    end else begin
      sec1_nxt = SEC_MAG_RED;
      w_full   = HUE_W'(6 * SECTOR_DEG) - hue_wrap;
    end
    w1_nxt = w_full[W_W-1:0];

    twol   = {in_lightness, 1'b0};
    l_fold = (twol >= HUE_W'(CH_MAX)) ? twol - HUE_W'(CH_MAX) : HUE_W'(CH_MAX) - twol;
    a1_nxt = (color_mode_r == MODE_HSV) ? in_lightness : CH_MAX - l_fold[CH_W-1:0];
  end

  always_comb begin
    cn2_nxt = CN_W'(a1_r) * CN_W'(s1_r);
  end

  always_comb begin
    xw3_nxt = XW_W'(cn2_r) * XW_W'(w2_r);
    lw3     = (T_W+1)'(l2_r) * (T_W+1)'(LW_SCALE);
    kcn3    = (mode2_r == MODE_HSV) ? (T_W+1)'({cn2_r, 1'b0}) : (T_W+1)'(cn2_r);
    diff3   = lw3 - kcn3;
    t3_nxt  = diff3[T_W-1:0];
  end

  // scale to the common denominator, route C and X by sector and add the M offset
  always_comb begin
    c4 = NUM_W'(cn3_r) * NUM_W'(C_SCALE);
    x4 = {xw3_r, 1'b0};
    m4 = NUM_W'(t3_r) * NUM_W'(M_SCALE);
    unique case (sec3_r)
      SEC_RED_YEL: begin
        pr4 = c4;  pg4 = x4;  pb4 = '0;
      end
      SEC_YEL_GRN: begin
        pr4 = x4;  pg4 = c4;  pb4 = '0;
      end
      SEC_GRN_CYN: begin
        pr4 = '0;  pg4 = c4;  pb4 = x4;
      end
      SEC_CYN_BLU: begin
        pr4 = '0;  pg4 = x4;  pb4 = c4;
      end
      SEC_BLU_MAG: begin
        pr4 = x4;  pg4 = '0;  pb4 = c4;
      end
      default: begin
        pr4 = c4;  pg4 = '0;  pb4 = x4;
      end
    endcase
    numr_nxt = pr4 + m4;
    numg_nxt = pg4 + m4;
    numb_nxt = pb4 + m4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // advance payload every cycle
  always_ff @(posedge clk) begin
    sec1_r  <= sec1_nxt;
    w1_r    <= w1_nxt;
    a1_r    <= a1_nxt;
    s1_r    <= in_saturation;
    l1_r    <= in_lightness;
    mode1_r <= color_mode_r;

    sec2_r  <= sec1_r;
    w2_r    <= w1_r;
    l2_r    <= l1_r;
    mode2_r <= mode1_r;
    cn2_r   <= cn2_nxt;

    sec3_r  <= sec2_r;
    cn3_r   <= cn2_r;
    xw3_r   <= xw3_nxt;
    t3_r    <= t3_nxt;

    numr_r  <= numr_nxt;
    numg_r  <= numg_nxt;
    numb_r  <= numb_nxt;
  end

  hsl_div u_div_red (
    .clk (clk),
    .num (numr_r),
    .quo (out_red)
  );

  hsl_div u_div_green (
    .clk (clk),
    .num (numg_r),
    .quo (out_green)
  );

  hsl_div u_div_blue (
    .clk (clk),
    .num (numb_r),
    .quo (out_blue)
  );

  assign out_strobe = v5_r;

  assign gray_req  = start && !busy && in_saturation == '0;
  assign black_req = start && !busy && color_mode_r == MODE_HSV && in_lightness == '0;
  assign rgb_equal = out_red == out_green && out_green == out_blue;
  assign rgb_zero  = out_red == '0 && out_green == '0 && out_blue == '0;

  `HSL_ASSERT_DLY(a_latency, clk, rst_n, start && !busy, LATENCY, out_strobe)
  `HSL_ASSERT_IMP(a_no_ghost, clk, rst_n, out_strobe, $past(start && !busy, LATENCY))
  `HSL_ASSERT_DLY(a_gray, clk, rst_n, gray_req, LATENCY, rgb_equal)
  `HSL_ASSERT_DLY(a_hsv_black, clk, rst_n, black_req, LATENCY, rgb_zero)

endmodule

[tb/hsl_hsv_to_rgb_top_checker.sv]
// Checker that predicts every RGB result of the color converter and compares it.
`timescale 1ns / 1ps

module hsl_hsv_to_rgb_top_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [hsl_pkg::HUE_W-1:0] in_hue,
  input  logic [hsl_pkg::CH_W-1:0]  in_saturation,
  input  logic [hsl_pkg::CH_W-1:0]  in_lightness,
  input  logic                      out_strobe,
  input  logic [hsl_pkg::CH_W-1:0]  out_red,
  input  logic [hsl_pkg::CH_W-1:0]  out_green,
  input  logic [hsl_pkg::CH_W-1:0]  out_blue,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data,
  output int unsigned               fail_count,
  output int unsigned               pending
);
  import hsl_pkg::*;

  localparam int unsigned HSL_SCALE = 30600;
  localparam int unsigned HSV_SCALE = 15300;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  lum;
    logic             mode;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } rgb_pixel_t;

  color_mode_t mode_q;
  rgb_pixel_t  rgb_q[$];

  function automatic logic [CH_W-1:0] scale_channel(int unsigned part, int unsigned offs,
                                                    int unsigned den);
    int unsigned v;
    v = (part + offs) / den;
    return (v > 255) ? CH_MAX : v[CH_W-1:0];
  endfunction

  function automatic rgb_pixel_t convert_pixel(color_mode_t mode, logic [HUE_W-1:0] hue,
                                               logic [CH_W-1:0] sat, logic [CH_W-1:0] lum);
    rgb_pixel_t  px;
    int unsigned h, s, l, hm, w, fold, cn, c, x, offs, den;
    logic [CH_W-1:0] cc, xc, zc;
    sector_t     sec;
    h = 32'(hue);
    s = 32'(sat);
    l = 32'(lum);
    if (h >= HUE_FULL) h = h - HUE_FULL;
    hm = h % (2 * SECTOR_DEG);
    w = (hm >= SECTOR_DEG) ? (2 * SECTOR_DEG - hm) : hm;
    if (mode == MODE_HSL) begin
      fold = (2 * l >= 255) ? (2 * l - 255) : (255 - 2 * l);
      cn   = (255 - fold) * s;
      c    = C_SCALE * cn;
      x    = 2 * cn * w;
      offs = M_SCALE * (LW_SCALE * l - cn);
      den  = HSL_SCALE;
    end else begin
      cn   = l * s;
      c    = M_SCALE * cn;
      x    = cn * w;
      offs = M_SCALE * (255 * l - cn);
      den  = HSV_SCALE;
    end
    cc  = scale_channel(c, offs, den);
    xc  = scale_channel(x, offs, den);
    zc  = scale_channel(0, offs, den);
    sec = sector_t'(h / SECTOR_DEG);
    px.hue  = hue;
    px.sat  = sat;
    px.lum  = lum;
    px.mode = mode;
    case (sec)
      SEC_RED_YEL: begin px.red = cc; px.green = xc; px.blue = zc; end
      SEC_YEL_GRN: begin px.red = xc; px.green = cc; px.blue = zc; end
      SEC_GRN_CYN: begin px.red = zc; px.green = cc; px.blue = xc; end
      SEC_CYN_BLU: begin px.red = zc; px.green = xc; px.blue = cc; end
      SEC_BLU_MAG: begin px.red = xc; px.green = zc; px.blue = cc; end
      default: begin px.red = cc; px.green = zc; px.blue = xc; end
    endcase
    return px;
  endfunction

  task automatic report_mismatch(string what, rgb_pixel_t px, logic [CH_W-1:0] got,
                                 logic [CH_W-1:0] want);
    if (fail_count < MAX_PRINTS)
      $display("%0t mismatch %s: mode=%0d hue=%0d sat=%0d lum=%0d got=%0d want=%0d",
               $realtime, what, px.mode, px.hue, px.sat, px.lum, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    mode_q = MODE_HSL;
  end

  always @(posedge clk) begin
    rgb_pixel_t px;
    if (!rst_n) begin
      mode_q = MODE_HSL;
    end else begin
      if (out_strobe) begin
        if (rgb_q.size() == 0) begin
          px = '0;
          report_mismatch("unexpected result", px, out_red, '0);
        end else begin
          px = rgb_q.pop_front();
          if (out_red !== px.red) report_mismatch("red", px, out_red, px.red);
          if (out_green !== px.green) report_mismatch("green", px, out_green, px.green);
          if (out_blue !== px.blue) report_mismatch("blue", px, out_blue, px.blue);
        end
      end
      if (start && !busy)
        rgb_q.push_back(convert_pixel(mode_q, in_hue, in_saturation, in_lightness));
      if (cfg_wr_en)
        mode_q = color_mode_t'(cfg_wr_data);
    end
    pending = rgb_q.size();
  end

endmodule

[tb/hsl_hsv_to_rgb_top_tb.sv]
// Testbench top: drives pixel requests and mode writes into the converter and gives the verdict.
`timescale 1ns / 1ps

module hsl_hsv_to_rgb_top_tb;
  import hsl_pkg::*;

  localparam int RANDOM_PHASE_ITEMS = 125;
  localparam int CYCLE_LIMIT = 200000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [HUE_W-1:0]  in_hue;
  logic [CH_W-1:0]   in_saturation;
  logic [CH_W-1:0]   in_lightness;
  logic              out_strobe;
  logic [CH_W-1:0]   out_red;
  logic [CH_W-1:0]   out_green;
  logic [CH_W-1:0]   out_blue;
  logic              cfg_wr_en;
  logic              cfg_wr_data;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       cycle_count;
  logic              req_taken;
  bit                dense;

  hsl_hsv_to_rgb_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_lightness  (in_lightness),
    .out_strobe    (out_strobe),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  hsl_hsv_to_rgb_top_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_lightness  (in_lightness),
    .out_strobe    (out_strobe),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    req_taken <= start && !busy;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_pixel(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                            logic [CH_W-1:0] lum);
    int gap;
    if ($urandom_range(0, 15) == 0) dense = !dense;
    gap = dense ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_lightness  <= lum;
    do @(negedge clk); while (!req_taken);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_mode(color_mode_t mode);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_directed_set();
    send_pixel(9'd0,   8'd255, 8'd127);
    send_pixel(9'd59,  8'd255, 8'd128);
    send_pixel(9'd60,  8'd200, 8'd100);
    send_pixel(9'd119, 8'd255, 8'd255);
    send_pixel(9'd180, 8'd255, 8'd128);
    send_pixel(9'd240, 8'd128, 8'd64);
    send_pixel(9'd299, 8'd255, 8'd200);
    send_pixel(9'd359, 8'd255, 8'd128);
    // hue past 359 wraps around the wheel
    send_pixel(9'd360, 8'd255, 8'd128);
    send_pixel(9'd511, 8'd255, 8'd255);
    send_pixel(9'd100, 8'd0,   8'd180);
    send_pixel(9'd200, 8'd255, 8'd0);
  endtask

  function automatic logic [CH_W-1:0] draw_level();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? CH_MAX : '0;
    return CH_W'($urandom_range(0, 255));
  endfunction

  task automatic run_random_phase(int n);
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    for (int i = 0; i < n; i++) begin
      hue = ($urandom_range(0, 7) == 0) ? HUE_W'($urandom_range(HUE_FULL, 511))
                                        : HUE_W'($urandom_range(0, HUE_FULL - 1));
      sat = draw_level();
      send_pixel(hue, sat, draw_level());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_hue        = '0;
    in_saturation = '0;
    in_lightness  = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = MODE_HSL;
    dense         = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_mode(MODE_HSL);
    run_directed_set();
    set_mode(MODE_HSV);
    run_directed_set();

    for (int p = 0; p < 4; p++) begin
      set_mode((p % 2 == 0) ? MODE_HSV : MODE_HSL);
      run_random_phase(RANDOM_PHASE_ITEMS);
    end

    drain_results();
    repeat (LATENCY + 4) @(negedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/hsl_pkg.sv
rtl/hsl_div.sv
rtl/hsl_hsv_to_rgb_top.sv
tb/hsl_hsv_to_rgb_top_checker.sv
tb/hsl_hsv_to_rgb_top_tb.sv
